[sv/tgad_pkg.sv]
// ============================================================================
// tgad_pkg
// Types and constants shared by the true-color TGA byte-stream decoder.
// ============================================================================
package tgad_pkg;

    // Decoder phase, one-hot encoded.
    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_IDSKIP = 5'b00010,
        PH_PACKET = 5'b00100,
        PH_PIXEL  = 5'b01000,
        PH_IDLE   = 5'b10000
    } phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } res_kind_t;

    // Error codes carried on error results.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_COLOR_MAP = 3'd1,
        ERR_IMG_TYPE  = 3'd2,
        ERR_DEPTH     = 3'd3,
        ERR_TRUNCATED = 3'd4
    } err_code_t;

    // Header byte offsets that carry fields we use.
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_DESC      = 5'd17;

    // Header field values.
    localparam logic [7:0] IMG_TYPE_RAW   = 8'd2;
    localparam logic [7:0] IMG_TYPE_RLE   = 8'd10;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;
    localparam int         DESC_TOP_BIT   = 5;
    localparam int         PKT_RUN_BIT    = 7;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

    // Pixel byte positions within one stored pixel (B, G, R, A).
    localparam logic [1:0] PIX_BLUE  = 2'd0;
    localparam logic [1:0] PIX_GREEN = 2'd1;
    localparam logic [1:0] PIX_RED   = 2'd2;
    localparam logic [1:0] PIX_ALPHA = 2'd3;

    // Row divider: quotient bits and step counter width.
    localparam int QUOT_W = 8;
    localparam int STEP_W = $clog2(QUOT_W);

    // One result item.
    typedef struct packed {
        res_kind_t   kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [7:0]  repeat_res;
        err_code_t   error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        image_done;
    } result_t;

    // Request to the row divider.
    typedef struct packed {
        logic        start;
        logic        clear;
        logic [16:0] dividend;
        logic [15:0] divisor;
        logic [15:0] base_y;
    } div_req_t;

    // Status from the row divider.
    typedef struct packed {
        logic        busy;
        logic        fin;
        logic [15:0] x;
        logic [15:0] y;
    } div_stat_t;

endpackage

[sv/tgad_byte_if.sv]
// ============================================================================
// tgad_byte_if
// Valid/ready channel that carries one byte of the file stream per request.
// ============================================================================
interface tgad_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

[sv/tgad_result_if.sv]
// ============================================================================
// tgad_result_if
// Valid/ready channel that carries one decoder result per request.
// ============================================================================
interface tgad_result_if
    import tgad_pkg::*;
;

    logic        valid;
    logic        ready;
    res_kind_t   kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [7:0]  repeat_res;
    err_code_t   error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        image_done;

    modport source (
        output valid, output kind, output red, output green, output blue,
        output alpha, output dest_x, output dest_y, output repeat_res,
        output error_code, output image_width, output image_height,
        output image_done, input ready
    );
    modport sink (
        input valid, input kind, input red, input green, input blue,
        input alpha, input dest_x, input dest_y, input repeat_res,
        input error_code, input image_width, input image_height,
        input image_done, output ready
    );

endinterface

[sv/tgad_rowdiv.sv]
// ============================================================================
// tgad_rowdiv
// Iterative divider that splits a linear column offset into a column and a
// row advance, one quotient bit per cycle.
// ============================================================================
module tgad_rowdiv
    import tgad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_stat_t stat
);

    logic              busy_reg;
    logic              fin_reg;
    logic [STEP_W-1:0] step_reg;
    logic [15:0]       rem_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [15:0]       divisor_reg;
    logic [15:0]       base_y_reg;

    logic [16:0]       trial;
    logic [16:0]       diff;
    logic              fits;
    logic [15:0]       rem_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    // The partial remainder always stays below the divisor, so it fits 16 bits.
    always_comb
    begin
        trial    = {rem_reg, low_reg[QUOT_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? diff[15:0] : trial[15:0];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (req.clear)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(QUOT_W - 1))
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
        else
        begin
            fin_reg <= 1'b0;
        end
    end

    // The quotient is known to fit QUOT_W bits, so the upper dividend bits
    // start out as the partial remainder.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= 16'(req.dividend[16:QUOT_W]);
            low_reg     <= req.dividend[QUOT_W-1:0];
            quot_reg    <= '0;
            divisor_reg <= req.divisor;
            base_y_reg  <= req.base_y;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg | fin_reg;
    assign stat.fin  = fin_reg;
    assign stat.x    = rem_reg;
    assign stat.y    = base_y_reg + 16'(quot_reg);

endmodule

[sv/tgad_parser.sv]
// ============================================================================
// tgad_parser
// Header parser, packet decoder and pixel assembler. Each accepted byte
// updates the parser state and may produce one result in the same cycle.
// ============================================================================
module tgad_parser
    import tgad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic [7:0] data_byte,
    input  logic      last_byte,
    input  div_stat_t div_stat,
    output div_req_t  div_req,
    output result_t   res,
    output logic      res_valid,
    output logic      hold
);

    phase_t      phase_reg,    phase_next;
    logic [4:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic [7:0]  id_skip_reg,  id_skip_next;
    logic        is_rle_reg,   is_rle_next;
    logic        has_alpha_reg, has_alpha_next;
    logic        top_reg,      top_next;
    logic [15:0] width_reg,    width_next;
    logic [15:0] height_reg,   height_next;
    logic [31:0] area_reg,     area_next;
    logic [31:0] remain_reg,   remain_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic        pkt_run_reg,  pkt_run_next;
    logic [23:0] pix_reg,      pix_next;
    logic [1:0]  pix_idx_reg,  pix_idx_next;
    logic [15:0] src_x_reg,    src_x_next;
    logic [15:0] src_y_reg,    src_y_next;
    err_code_t   err_reg,      err_next;

    logic        pix_done;
    logic [7:0]  pkt_cnt;
    logic [7:0]  reps;
    logic [16:0] total;
    logic [16:0] wrapped;
    logic [16:0] width_ext;
    logic [31:0] remain_after;
    phase_t      data_phase;

    // Pixel-phase bytes wait while a row split is still in flight.
    assign hold = div_stat.busy && (phase_reg == PH_PIXEL);

    assign data_phase = is_rle_reg ? PH_PACKET : PH_PIXEL;
    assign width_ext  = {1'b0, width_reg};

    // Next-state and result logic.
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        id_skip_next   = id_skip_reg;
        is_rle_next    = is_rle_reg;
        has_alpha_next = has_alpha_reg;
        top_next       = top_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        area_next      = area_reg;
        remain_next    = remain_reg;
        pkt_left_next  = pkt_left_reg;
        pkt_run_next   = pkt_run_reg;
        pix_next       = pix_reg;
        pix_idx_next   = pix_idx_reg;
        src_x_next     = src_x_reg;
        src_y_next     = src_y_reg;
        err_next       = err_reg;
        res            = '0;
        res_valid      = 1'b0;
        div_req        = '0;
        pix_done       = 1'b0;
        pkt_cnt        = '0;
        reps           = 8'd1;
        total          = '0;
        wrapped        = '0;
        remain_after   = remain_reg;

        // A finished row split lands in the source position.
        if (div_stat.fin)
        begin
            src_x_next = div_stat.x;
            src_y_next = div_stat.y;
        end

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    case (hdr_cnt_reg)
                        HDR_ID_LEN:    id_skip_next = data_byte;
                        HDR_CMAP_TYPE:
                        begin
                            if (data_byte != 8'd0 && err_reg == ERR_NONE)
                                err_next = ERR_COLOR_MAP;
                        end
                        HDR_IMG_TYPE:
                        begin
                            is_rle_next = (data_byte == IMG_TYPE_RLE);
                            if (data_byte != IMG_TYPE_RAW && data_byte != IMG_TYPE_RLE
                                && err_reg == ERR_NONE)
                                err_next = ERR_IMG_TYPE;
                        end
                        HDR_WIDTH_LO:  width_next[7:0]   = data_byte;
                        HDR_WIDTH_HI:  width_next[15:8]  = data_byte;
                        HDR_HEIGHT_LO: height_next[7:0]  = data_byte;
                        HDR_HEIGHT_HI: height_next[15:8] = data_byte;
                        HDR_DEPTH:
                        begin
                            has_alpha_next = (data_byte == DEPTH_32);
                            area_next      = 32'(width_reg) * 32'(height_reg);
                            if (data_byte != DEPTH_24 && data_byte != DEPTH_32
                                && err_reg == ERR_NONE)
                                err_next = ERR_DEPTH;
                        end
                        HDR_DESC:      top_next = data_byte[DESC_TOP_BIT];
                        default:       ;
                    endcase

                    if (hdr_cnt_reg != HDR_DESC)
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        if (err_reg != ERR_NONE)
                        begin
                            res.kind       = KIND_ERROR;
                            res.error_code = err_reg;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            res.kind         = KIND_HEADER;
                            res.image_width  = width_reg;
                            res.image_height = height_reg;
                            src_x_next       = '0;
                            src_y_next       = '0;
                            remain_next      = area_reg;
                            if (area_reg == 32'd0)
                            begin
                                res.image_done = 1'b1;
                                phase_next     = PH_IDLE;
                            end
                            else if (id_skip_reg != 8'd0)
                                phase_next = PH_IDSKIP;
                            else
                                phase_next = data_phase;
                        end
                    end
                end

                PH_IDSKIP:
                begin
                    id_skip_next = id_skip_reg - 1'b1;
                    if (id_skip_reg == 8'd1)
                        phase_next = data_phase;
                end

                PH_PACKET:
                begin
                    // Packet count, clipped to the pixels that remain.
                    pkt_cnt = {1'b0, data_byte[6:0]} + 8'd1;
                    if ({24'd0, pkt_cnt} > remain_reg)
                        pkt_cnt = remain_reg[7:0];
                    pkt_left_next = pkt_cnt;
                    pkt_run_next  = data_byte[PKT_RUN_BIT];
                    pix_idx_next  = '0;
                    phase_next    = PH_PIXEL;
                end

                PH_PIXEL:
                begin
                    case (pix_idx_reg)
                        PIX_BLUE:  pix_next[7:0]   = data_byte;
                        PIX_GREEN: pix_next[15:8]  = data_byte;
                        PIX_RED:   pix_next[23:16] = data_byte;
                        default:   ;
                    endcase
                    pix_idx_next = pix_idx_reg + 1'b1;
                    pix_done     = has_alpha_reg ? (pix_idx_reg == PIX_ALPHA)
                                                 : (pix_idx_reg == PIX_RED);

                    if (pix_done)
                    begin
                        if (is_rle_reg)
                        begin
                            if (pkt_run_reg)
                            begin
                                reps          = pkt_left_reg;
                                pkt_left_next = '0;
                            end
                            else
                            begin
                                pkt_left_next = pkt_left_reg - 1'b1;
                            end
                        end
                        if (reps == 8'd0)
                            reps = 8'd1;

                        res_valid      = 1'b1;
                        res.kind       = KIND_PIXEL;
                        res.red        = pix_next[23:16];
                        res.green      = pix_next[15:8];
                        res.blue       = pix_next[7:0];
                        res.alpha      = (pix_idx_reg == PIX_ALPHA) ? data_byte
                                                                    : ALPHA_OPAQUE;
                        res.dest_x     = src_x_reg;
                        res.dest_y     = top_reg ? src_y_reg
                                                 : (height_reg - 16'd1 - src_y_reg);
                        res.repeat_res = reps;
                        pix_next       = '0;
                        pix_idx_next   = '0;

                        // Advance the source position; long runs go to the divider.
                        total   = {1'b0, src_x_reg} + {9'd0, reps};
                        wrapped = total - width_ext;
                        if (total < width_ext)
                        begin
                            src_x_next = total[15:0];
                        end
                        else if (wrapped < width_ext)
                        begin
                            src_x_next = wrapped[15:0];
                            src_y_next = src_y_reg + 16'd1;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = total;
                            div_req.divisor  = width_reg;
                            div_req.base_y   = src_y_reg;
                        end

                        remain_after = remain_reg - {24'd0, reps};
                        remain_next  = remain_after;
                        if (remain_after == 32'd0)
                        begin
                            res.image_done = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                        else if (is_rle_reg && pkt_left_next == 8'd0)
                        begin
                            phase_next = PH_PACKET;
                        end
                    end
                end

                PH_IDLE:
                begin
                end

                default:
                begin
                end
            endcase

            // The final byte of a file rearms the decoder; an unfinished image
            // reports truncation in place of any other result.
            if (last_byte)
            begin
                if (phase_next != PH_IDLE)
                begin
                    res            = '0;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNCATED;
                    res_valid      = 1'b1;
                end
                phase_next     = PH_HEADER;
                hdr_cnt_next   = '0;
                id_skip_next   = '0;
                is_rle_next    = 1'b0;
                has_alpha_next = 1'b0;
                top_next       = 1'b0;
                width_next     = '0;
                height_next    = '0;
                remain_next    = '0;
                pkt_left_next  = '0;
                pkt_run_next   = 1'b0;
                pix_next       = '0;
                pix_idx_next   = '0;
                src_x_next     = '0;
                src_y_next     = '0;
                err_next       = ERR_NONE;
                div_req        = '0;
                div_req.clear  = 1'b1;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= '0;
            id_skip_reg   <= '0;
            is_rle_reg    <= 1'b0;
            has_alpha_reg <= 1'b0;
            top_reg       <= 1'b0;
            width_reg     <= '0;
            height_reg    <= '0;
            remain_reg    <= '0;
            pkt_left_reg  <= '0;
            pkt_run_reg   <= 1'b0;
            pix_reg       <= '0;
            pix_idx_reg   <= '0;
            src_x_reg     <= '0;
            src_y_reg     <= '0;
            err_reg       <= ERR_NONE;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            id_skip_reg   <= id_skip_next;
            is_rle_reg    <= is_rle_next;
            has_alpha_reg <= has_alpha_next;
            top_reg       <= top_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            remain_reg    <= remain_next;
            pkt_left_reg  <= pkt_left_next;
            pkt_run_reg   <= pkt_run_next;
            pix_reg       <= pix_next;
            pix_idx_reg   <= pix_idx_next;
            src_x_reg     <= src_x_next;
            src_y_reg     <= src_y_next;
            err_reg       <= err_next;
        end
    end

    // Image area, registered after the multiply at the depth byte.
    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
    end

endmodule

[sv/tgad_out_stage.sv]
// ============================================================================
// tgad_out_stage
// Result register that holds one result until the consumer takes it.
// ============================================================================
module tgad_out_stage
    import tgad_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  result_t        res,
    output logic           free,
    tgad_result_if.source  results
);

    logic    valid_reg;
    result_t res_reg;

    // The register can take a new result when empty or when drained this cycle.
    assign free = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (results.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    // Drive the result channel from the register.
    assign results.valid        = valid_reg;
    assign results.kind         = res_reg.kind;
    assign results.red          = res_reg.red;
    assign results.green        = res_reg.green;
    assign results.blue         = res_reg.blue;
    assign results.alpha        = res_reg.alpha;
    assign results.dest_x       = res_reg.dest_x;
    assign results.dest_y       = res_reg.dest_y;
    assign results.repeat_res   = res_reg.repeat_res;
    assign results.error_code   = res_reg.error_code;
    assign results.image_width  = res_reg.image_width;
    assign results.image_height = res_reg.image_height;
    assign results.image_done   = res_reg.image_done;

endmodule

[sv/tga_truecolor_rle_decoder_top.sv]
// ============================================================================
// tga_truecolor_rle_decoder_top
// A result is registered and is valid in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the result register is free; after a run packet
// that ends two or more rows past its start, the row divider runs and pixel bytes wait
// for it. rst_n clears parser state other than the image area, and the valid flags.
// ============================================================================
module tga_truecolor_rle_decoder_top
    import tgad_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tgad_byte_if.sink     file_bytes,
    tgad_result_if.source results
);

    logic      accept;
    logic      free;
    logic      hold;
    logic      res_valid;
    result_t   res;
    div_req_t  div_req;
    div_stat_t div_stat;

    // Input request handshake.
    assign file_bytes.ready = free && !hold;
    assign accept           = file_bytes.valid && file_bytes.ready;

    tgad_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (file_bytes.data_byte),
        .last_byte (file_bytes.last_byte),
        .div_stat  (div_stat),
        .div_req   (div_req),
        .res       (res),
        .res_valid (res_valid),
        .hold      (hold)
    );

    tgad_rowdiv u_rowdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    tgad_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_valid),
        .res     (res),
        .free    (free),
        .results (results)
    );

endmodule

[tb/sv/tb_tga_truecolor_rle_decoder_top.sv]
// ============================================================================
// tb_tga_truecolor_rle_decoder_top
// Self-checking bench for the byte-stream TGA decoder. Whole files are built
// in memory (good raw and run-length images, rejected headers, empty images,
// cut-off files and noise), streamed in one byte per request with random
// gaps, and every result is compared with a bit-exact software decoder.
// ============================================================================
import tgad_pkg::*;

// Software decoder plus the queue of results it says the block owes us.
class tga_result_board;

    phase_t      phase;
    logic [4:0]  hdr_idx;
    logic [7:0]  id_left;
    bit          rle;
    bit          alpha_on;
    bit          top_down;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  pkt_left;
    bit          pkt_run;
    logic [23:0] pix_acc;
    logic [1:0]  pix_idx;
    logic [15:0] col;
    logic [15:0] row;
    err_code_t   hdr_err;

    result_t     results_due[$];
    int          failures;
    int          n_header;
    int          n_pixel;
    int          n_done;
    int          n_trunc;
    int          n_reject;
    int          max_repeat;

    function new();
        clear_state();
        failures   = 0;
        n_header   = 0;
        n_pixel    = 0;
        n_done     = 0;
        n_trunc    = 0;
        n_reject   = 0;
        max_repeat = 0;
    endfunction

    function void clear_state();
        phase    = PH_HEADER;
        hdr_idx  = '0;
        id_left  = '0;
        rle      = 1'b0;
        alpha_on = 1'b0;
        top_down = 1'b0;
        width    = '0;
        height   = '0;
        pkt_left = '0;
        pkt_run  = 1'b0;
        pix_acc  = '0;
        pix_idx  = '0;
        col      = '0;
        row      = '0;
        hdr_err  = ERR_NONE;
    endfunction

    function logic [31:0] pixels_to_go();
        if (row >= height)
        begin
            return 32'd0;
        end
        return ({16'd0, height} - {16'd0, row}) * {16'd0, width} - {16'd0, col};
    endfunction

    function phase_t body_phase();
        return rle ? PH_PACKET : PH_PIXEL;
    endfunction

    // Advance the decoder by one accepted byte and queue any result it makes.
    function void decode_byte(logic [7:0] b, bit last);
        result_t     r;
        bit          made;
        logic [31:0] cnt;
        logic [31:0] reps;
        logic [31:0] total;
        logic [7:0]  a_byte;
        logic [1:0]  done_idx;

        r    = '0;
        made = 1'b0;
        case (phase)
            PH_HEADER:
            begin
                case (hdr_idx)
                    HDR_ID_LEN:    id_left = b;
                    HDR_CMAP_TYPE:
                    begin
                        if (b != 8'd0 && hdr_err == ERR_NONE)
                            hdr_err = ERR_COLOR_MAP;
                    end
                    HDR_IMG_TYPE:
                    begin
                        rle = (b == IMG_TYPE_RLE);
                        if (b != IMG_TYPE_RAW && b != IMG_TYPE_RLE && hdr_err == ERR_NONE)
                            hdr_err = ERR_IMG_TYPE;
                    end
                    HDR_WIDTH_LO:  width[7:0]   = b;
                    HDR_WIDTH_HI:  width[15:8]  = b;
                    HDR_HEIGHT_LO: height[7:0]  = b;
                    HDR_HEIGHT_HI: height[15:8] = b;
                    HDR_DEPTH:
                    begin
                        alpha_on = (b == DEPTH_32);
                        if (b != DEPTH_24 && b != DEPTH_32 && hdr_err == ERR_NONE)
                            hdr_err = ERR_DEPTH;
                    end
                    HDR_DESC:      top_down = b[DESC_TOP_BIT];
                    default:       ;
                endcase

                if (hdr_idx != HDR_DESC)
                begin
                    hdr_idx = hdr_idx + 5'd1;
                end
                else
                begin
                    made = 1'b1;
                    if (hdr_err != ERR_NONE)
                    begin
                        r.kind       = KIND_ERROR;
                        r.error_code = hdr_err;
                        phase        = PH_IDLE;
                    end
                    else
                    begin
                        r.kind         = KIND_HEADER;
                        r.image_width  = width;
                        r.image_height = height;
                        col = '0;
                        row = '0;
                        if (pixels_to_go() == 32'd0)
                        begin
                            r.image_done = 1'b1;
                            phase        = PH_IDLE;
                        end
                        else if (id_left != 8'd0)
                            phase = PH_IDSKIP;
                        else
                            phase = body_phase();
                    end
                end
            end

            PH_IDSKIP:
            begin
                id_left = id_left - 8'd1;
                if (id_left == 8'd0)
                    phase = body_phase();
            end

            // Packet header: count is clipped to what is left of the image.
            PH_PACKET:
            begin
                cnt = {25'd0, b[6:0]} + 32'd1;
                if (cnt > pixels_to_go())
                    cnt = pixels_to_go();
                pkt_left = cnt[7:0];
                pkt_run  = b[PKT_RUN_BIT];
                pix_idx  = '0;
                phase    = PH_PIXEL;
            end

            // Pixel bytes arrive as B, G, R and optionally A.
            PH_PIXEL:
            begin
                a_byte = ALPHA_OPAQUE;
                if (pix_idx != PIX_ALPHA)
                    pix_acc[8*pix_idx +: 8] = b;
                else
                    a_byte = b;
                pix_idx = pix_idx + 2'd1;
                // With alpha the index wraps back to blue when the pixel is whole.
                done_idx = alpha_on ? PIX_BLUE : PIX_ALPHA;
                if (pix_idx == done_idx)
                begin
                    reps = 32'd1;
                    if (rle)
                    begin
                        if (pkt_run)
                        begin
                            reps     = {24'd0, pkt_left};
                            pkt_left = '0;
                        end
                        else
                            pkt_left = pkt_left - 8'd1;
                    end
                    if (reps == 32'd0)
                        reps = 32'd1;

                    made         = 1'b1;
                    r.kind       = KIND_PIXEL;
                    r.red        = pix_acc[23:16];
                    r.green      = pix_acc[15:8];
                    r.blue       = pix_acc[7:0];
                    r.alpha      = a_byte;
                    r.dest_x     = col;
                    r.dest_y     = top_down ? row : height - 16'd1 - row;
                    r.repeat_res = reps[7:0];
                    pix_acc      = '0;
                    pix_idx      = '0;

                    total = {16'd0, col} + reps;
                    if (width != 16'd0)
                    begin
                        row = row + 16'(total / {16'd0, width});
                        col = 16'(total % {16'd0, width});
                    end
                    if (pixels_to_go() == 32'd0)
                    begin
                        r.image_done = 1'b1;
                        phase        = PH_IDLE;
                    end
                    else if (rle && pkt_left == 8'd0)
                        phase = PH_PACKET;
                end
            end

            default: ;
        endcase

        // End of file before the image is whole overrides anything else.
        if (last)
        begin
            if (phase != PH_IDLE)
            begin
                r            = '0;
                r.kind       = KIND_ERROR;
                r.error_code = ERR_TRUNCATED;
                made         = 1'b1;
            end
            clear_state();
        end

        if (made)
            results_due.push_back(r);
    endfunction

    function string show(result_t r);
        return $sformatf({"kind=%0d rgba=%02h/%02h/%02h/%02h x=%0d y=%0d rep=%0d",
                          " err=%0d w=%0d h=%0d done=%0d"},
                         r.kind, r.red, r.green, r.blue, r.alpha, r.dest_x, r.dest_y,
                         r.repeat_res, r.error_code, r.image_width, r.image_height,
                         r.image_done);
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    // Compare one accepted result with the oldest one owed.
    function void check_result(result_t got);
        result_t want;
        string   diffs;

        if (results_due.size() == 0)
        begin
            flag({"result with none owed: ", show(got)});
            return;
        end
        want  = results_due.pop_front();
        diffs = "";
        if (got.kind !== want.kind)                 diffs = {diffs, " kind"};
        if (got.red !== want.red)                   diffs = {diffs, " red"};
        if (got.green !== want.green)               diffs = {diffs, " green"};
        if (got.blue !== want.blue)                 diffs = {diffs, " blue"};
        if (got.alpha !== want.alpha)               diffs = {diffs, " alpha"};
        if (got.dest_x !== want.dest_x)             diffs = {diffs, " dest_x"};
        if (got.dest_y !== want.dest_y)             diffs = {diffs, " dest_y"};
        if (got.repeat_res !== want.repeat_res)     diffs = {diffs, " repeat_res"};
        if (got.error_code !== want.error_code)     diffs = {diffs, " error_code"};
        if (got.image_width !== want.image_width)   diffs = {diffs, " image_width"};
        if (got.image_height !== want.image_height) diffs = {diffs, " image_height"};
        if (got.image_done !== want.image_done)     diffs = {diffs, " image_done"};
        if (diffs != "")
            flag({"fields", diffs, "\n  expected ", show(want), "\n  actual   ", show(got)});

        case (want.kind)
            KIND_HEADER: n_header++;
            KIND_PIXEL:
            begin
                n_pixel++;
                if (int'(want.repeat_res) > max_repeat)
                    max_repeat = int'(want.repeat_res);
            end
            default:
            begin
                if (want.error_code == ERR_TRUNCATED)
                    n_trunc++;
                else
                    n_reject++;
            end
        endcase
        if (want.image_done)
            n_done++;
    endfunction

endclass

module tb_tga_truecolor_rle_decoder_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES   = 1600;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int HOLD_AT_RESULT = 60;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_CYCLES   = 32;

    logic clk;
    logic rst_n;

    tgad_byte_if   file_bytes();
    tgad_result_if results();

    tga_truecolor_rle_decoder_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .file_bytes (file_bytes),
        .results    (results)
    );

    tga_result_board board = new();

    logic [7:0] file_q[$];
    bit         tx_burst;
    int         bytes_sent;
    int         files_sent;
    int         cycles;

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Test completed with failures");
        $finish;
    end

    // File construction helpers; they append to file_q, and cut_file trims it.
    function automatic void add_bytes(int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(8'($urandom));
    endfunction

    function automatic void add_header(logic [7:0] id_len, logic [7:0] cmap,
                                       logic [7:0] itype, logic [15:0] w,
                                       logic [15:0] h, logic [7:0] depth, bit top);
        logic [7:0] desc;

        file_q.push_back(id_len);
        file_q.push_back(cmap);
        file_q.push_back(itype);
        add_bytes(9);
        file_q.push_back(w[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(h[15:8]);
        file_q.push_back(depth);
        desc = 8'($urandom);
        desc[DESC_TOP_BIT] = top;
        file_q.push_back(desc);
        add_bytes(int'(id_len));
    endfunction

    // Pixel data for npix pixels; run-length packets sometimes overrun the image.
    function automatic void add_pixels(bit rle, bit with_alpha, int npix);
        int left;
        int cnt;
        int take;
        bit run;

        if (!rle)
        begin
            add_bytes(npix * (with_alpha ? 4 : 3));
            return;
        end
        left = npix;
        while (left > 0)
        begin
            cnt  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            run  = 1'($urandom);
            take = (cnt < left) ? cnt : left;
            file_q.push_back({run, 7'(cnt - 1)});
            add_bytes((run ? 1 : take) * (with_alpha ? 4 : 3));
            left -= take;
        end
    endfunction

    function automatic void cut_file(int keep);
        while (file_q.size() > keep)
            void'(file_q.pop_back());
    endfunction

    // One random file; returns how many of its bytes the decoder acts on.
    function automatic int build_random_file();
        int          sel;
        int          useful;
        logic [7:0]  id_len;
        logic [7:0]  cmap;
        logic [7:0]  itype;
        logic [7:0]  depth;
        logic [15:0] w;
        logic [15:0] h;
        bit          rle;
        bit          a32;
        int          npix;

        sel    = $urandom_range(0, 19);
        rle    = 1'($urandom);
        a32    = 1'($urandom);
        itype  = rle ? IMG_TYPE_RLE : IMG_TYPE_RAW;
        depth  = a32 ? DEPTH_32 : DEPTH_24;
        cmap   = 8'd0;
        id_len = ($urandom_range(0, 29) == 0) ? 8'($urandom) :
                 ($urandom_range(0, 2) == 0)  ? 8'($urandom_range(1, 4)) : 8'd0;
        case ($urandom_range(0, 7))
            0, 1, 2, 3:
            begin
                w = 16'($urandom_range(1, 4));
                h = 16'($urandom_range(1, 8));
            end
            4, 5:
            begin
                w = 16'($urandom_range(1, 12));
                h = 16'($urandom_range(1, 4));
            end
            6:
            begin
                w = 16'($urandom_range(1, 2));
                h = 16'($urandom_range(9, 40));
            end
            default:
            begin
                w = 16'($urandom_range(13, 40));
                h = 16'($urandom_range(1, 3));
            end
        endcase

        if (sel <= 13)
        begin
            // Well-formed image, sometimes cut short or followed by junk.
            add_header(id_len, cmap, itype, w, h, depth, 1'($urandom));
            add_pixels(rle, a32, int'(w) * int'(h));
            useful = file_q.size();
            if (sel >= 12)
            begin
                cut_file($urandom_range(1, file_q.size() - 1));
                useful = file_q.size();
            end
            else if ($urandom_range(0, 4) == 0)
                add_bytes($urandom_range(1, 6));
        end
        else if (sel <= 15)
        begin
            // Rejected header: one or more of the three checks fail.
            sel = $urandom_range(1, 7);
            if (sel[0])
                cmap = 8'($urandom_range(1, 255));
            if (sel[1])
            begin
                do
                    itype = 8'($urandom);
                while (itype == IMG_TYPE_RAW || itype == IMG_TYPE_RLE);
            end
            if (sel[2])
            begin
                do
                    depth = 8'($urandom);
                while (depth == DEPTH_24 || depth == DEPTH_32);
            end
            add_header(id_len, cmap, itype, w, h, depth, 1'($urandom));
            useful = file_q.size();
            add_bytes($urandom_range(0, 8));
        end
        else if (sel == 16)
        begin
            // Empty image: no pixel data follows.
            case ($urandom_range(0, 2))
                0:       w = 16'd0;
                1:       h = 16'd0;
                default:
                begin
                    w = 16'd0;
                    h = 16'd0;
                end
            endcase
            if ($urandom_range(0, 1) == 0)
                h = (w == 16'd0) ? 16'($urandom) : 16'd0;
            add_header(id_len, cmap, itype, w, h, depth, 1'($urandom));
            useful = file_q.size();
            add_bytes($urandom_range(0, 3));
        end
        else if (sel == 17)
        begin
            add_bytes($urandom_range(1, 30));
            useful = file_q.size();
        end
        else
        begin
            // Large dimensions; only the first few pixels are sent.
            w = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
            h = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
            npix = (32'(w) * 32'(h) < 6) ? int'(w) * int'(h) : 6;
            add_header(8'd0, cmap, itype, w, h, depth, 1'($urandom));
            add_pixels(rle, a32, npix);
            useful = file_q.size();
        end
        return useful;
    endfunction

    // One byte request; the gap before it is drawn per byte.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;

        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            file_bytes.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        file_bytes.valid     <= 1'b1;
        file_bytes.data_byte <= b;
        file_bytes.last_byte <= last;
        do
            @(posedge clk);
        while (file_bytes.ready !== 1'b1);
        board.decode_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_file();
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
        file_q.delete();
        files_sent++;
    endtask

    // Result side: random stalls, one long hold-off, and checking.
    initial
    begin
        int      stall_left;
        int      taken;
        bit      rx_burst;
        result_t got;

        stall_left    = 0;
        taken         = 0;
        rx_burst      = 1'b0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (results.valid === 1'b1 && results.ready === 1'b1)
            begin
                got.kind         = results.kind;
                got.red          = results.red;
                got.green        = results.green;
                got.blue         = results.blue;
                got.alpha        = results.alpha;
                got.dest_x       = results.dest_x;
                got.dest_y       = results.dest_y;
                got.repeat_res   = results.repeat_res;
                got.error_code   = results.error_code;
                got.image_width  = results.image_width;
                got.image_height = results.image_height;
                got.image_done   = results.image_done;
                board.check_result(got);
                taken++;
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, 16);
                if (taken == HOLD_AT_RESULT)
                    stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= rst_n;
        end
    end

    // Main sequence: reset, directed files, random files, drain, verdict.
    initial
    begin
        int random_bytes;

        rst_n                = 1'b0;
        file_bytes.valid     = 1'b0;
        file_bytes.data_byte = 8'd0;
        file_bytes.last_byte = 1'b0;
        tx_burst             = 1'b0;
        bytes_sent           = 0;
        files_sent           = 0;
        random_bytes         = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Color map present.
        add_header(8'd0, 8'd1, IMG_TYPE_RAW, 16'd2, 16'd2, DEPTH_24, 1'b0);
        send_file();
        // Bad image type (and bad depth, which must not win), then ignored bytes.
        add_header(8'd0, 8'd0, 8'd3, 16'd2, 16'd2, 8'd8, 1'b0);
        add_bytes(3);
        send_file();
        // Bad depth on a run-length file.
        add_header(8'd0, 8'd0, IMG_TYPE_RLE, 16'd1, 16'd1, 8'd16, 1'b1);
        add_bytes(1);
        send_file();
        // Empty image: zero width, full height.
        add_header(8'd0, 8'd0, IMG_TYPE_RAW, 16'd0, 16'hFFFF, DEPTH_32, 1'b0);
        send_file();
        // 1x1 raw, bottom origin, one ID byte, bytes after the image.
        add_header(8'd1, 8'd0, IMG_TYPE_RAW, 16'd1, 16'd1, DEPTH_24, 1'b0);
        file_q.push_back(8'h00);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h80);
        add_bytes(2);
        send_file();
        // 3x2 run-length, top origin: raw packet of two, then a 128 run clipped to four.
        add_header(8'd0, 8'd0, IMG_TYPE_RLE, 16'd3, 16'd2, DEPTH_32, 1'b1);
        file_q.push_back(8'h01);
        repeat (4) file_q.push_back(8'hFF);
        repeat (4) file_q.push_back(8'h00);
        file_q.push_back(8'hFF);
        add_bytes(4);
        send_file();
        // Maximum size image cut off inside a pixel.
        add_header(8'd0, 8'd0, IMG_TYPE_RLE, 16'hFFFF, 16'hFFFF, DEPTH_24, 1'b0);
        file_q.push_back(8'h85);
        add_bytes(5);
        send_file();
        // File that ends inside the header.
        add_header(8'd0, 8'd0, IMG_TYPE_RAW, 16'd4, 16'd4, DEPTH_24, 1'b0);
        cut_file(6);
        send_file();

        while (random_bytes < RANDOM_BYTES)
        begin
            random_bytes += build_random_file();
            send_file();
        end
        file_bytes.valid <= 1'b0;

        while (board.results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d files (%0d bytes); checked %0d headers, %0d pixel runs, %0d full images.",
                 files_sent, bytes_sent, board.n_header, board.n_pixel, board.n_done);
        $display("Rejected %0d headers, %0d truncated files; longest run %0d; %0d mismatches.",
                 board.n_reject, board.n_trunc, board.max_repeat, board.failures);
        if (board.failures == 0 && board.results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
